@@ hdl/dad_pkg.sv @@
// ----------------------------------------------------------------------------
// Date adder package
// Shared constants, calendar functions and the control word of the
// accumulate unit used by the date adder.
// ----------------------------------------------------------------------------
package dad_pkg;

  // Calendar window handled by the block.
  localparam logic [11:0] YEAR_FIRST = 12'd1970;
  localparam logic [11:0] YEAR_LAST  = 12'd2099;
  localparam logic [3:0]  MONTH_LAST = 4'd12;

  // Day count since 1.1.1970 tops out near 113000, so 17 bits suffice.
  localparam int SERIAL_W = 17;
  // A year or month length is at most 366.
  localparam int LEN_W = 9;

  localparam logic [LEN_W-1:0] DAYS_COMMON_YEAR = 9'd365;
  localparam logic [LEN_W-1:0] DAYS_FEB_COMMON  = 9'd28;

  // Control word of the shared add / subtract unit.
  typedef struct packed {
    logic             sub;
    logic [LEN_W-1:0] len;
  } dad_op_t;

  // Leap rule. Inside 1970..2099 the century exception never applies
  // (2000 is divisible by 400), so divisibility by four is exact.
  function automatic logic is_leap(input logic [11:0] year);
    is_leap = (year[1:0] == 2'b00);
  endfunction

  function automatic logic [LEN_W-1:0] year_len(input logic [11:0] year);
    year_len = DAYS_COMMON_YEAR + LEN_W'(is_leap(year));
  endfunction

  // Month must be 1..12; February grows by one day in leap years.
  function automatic logic [LEN_W-1:0] month_len(input logic [3:0] month,
                                                input logic [11:0] year);
    logic [LEN_W-1:0] len;
    len = 9'd31;
    case (month)
      4'd2: len = DAYS_FEB_COMMON + LEN_W'(is_leap(year));
      4'd4, 4'd6, 4'd9, 4'd11: len = 9'd30;
      default: len = 9'd31;
    endcase
    month_len = len;
  endfunction

endpackage

@@ hdl/dad_accum.sv @@
// ----------------------------------------------------------------------------
// Date adder accumulate unit
// Shared adder / subtractor with a compare, used by every step of the
// date adder's sequencer.
// ----------------------------------------------------------------------------
module dad_accum (
  input  dad_pkg::dad_op_t             op,
  input  logic [dad_pkg::SERIAL_W-1:0] acc,
  output logic [dad_pkg::SERIAL_W-1:0] result,
  output logic                         ge
);
  import dad_pkg::*;

  logic [SERIAL_W-1:0] len_ext;

  // One wide add or subtract, plus the compare that gates a subtract.
  assign len_ext = SERIAL_W'(op.len);
  assign ge      = (acc >= len_ext);
  assign result  = op.sub ? (acc - len_ext) : (acc + len_ext);

endmodule

@@ hdl/date_add_days_top.sv @@
// ----------------------------------------------------------------------------
// Date adder top level
// Adds a day count to a Gregorian date between 1970 and 2099.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one beat per request: start_day, start_month,
//   start_year and days_to_add. An out-of-range start is taken as 1.1.1970.
//   The output channel carries one beat per request: end_day, end_month,
//   end_year. A result past 2099 is reported as 1.1.1970.
//   Sequence: the start date is turned into a day count one year and then one
//   month per cycle, and the count is turned back into a date the same way,
//   all through a single shared add / compare unit. in_stall stays high until
//   the result has moved into the output register.
//   The result sits in an output register, so a new request is taken as soon
//   as the sequencer is free, even while that result waits. If the receiver
//   keeps out_stall high, the next result waits in the sequencer.
//   Reset clears the sequencer and out_valid; no beat is lost or repeated.
// ----------------------------------------------------------------------------
module date_add_days_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  start_day,
  input  logic [3:0]  start_month,
  input  logic [11:0] start_year,
  input  logic [15:0] days_to_add,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  end_day,
  output logic [3:0]  end_month,
  output logic [11:0] end_year
);
  import dad_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_YACC = 3'd1;
  localparam logic [2:0] S_MACC = 3'd2;
  localparam logic [2:0] S_YDEC = 3'd3;
  localparam logic [2:0] S_MDEC = 3'd4;
  localparam logic [2:0] S_HOLD = 3'd5;

  logic [2:0]          state, state_next;
  logic [SERIAL_W-1:0] serial, serial_next;
  logic [11:0]         yr, yr_next;
  logic [3:0]          mo, mo_next;
  logic [11:0]         tgt_y, tgt_y_next;
  logic [3:0]          tgt_m, tgt_m_next;
  logic [4:0]          res_d, res_d_next;
  logic [3:0]          res_m, res_m_next;
  logic [11:0]         res_y, res_y_next;
  logic                out_load;

  dad_op_t             op;
  logic [SERIAL_W-1:0] alu_result;
  logic                alu_ge;
  logic                in_ok;
  logic                in_beat;

  assign in_stall = (state != S_IDLE);
  assign in_beat  = in_valid && !in_stall;
  assign out_load = (state == S_HOLD) && (!out_valid || !out_stall);

  // Range check of the start date.
  assign in_ok = (start_day != 5'd0) && (start_month != 4'd0) &&
                 (start_month <= MONTH_LAST) &&
                 (start_year >= YEAR_FIRST) && (start_year <= YEAR_LAST);

  // Length fed to the shared unit, chosen by the current step.
  always_comb begin
    op.sub = 1'b0;
    op.len = year_len(yr);
    unique case (state)
      S_YACC: begin
        op.sub = 1'b0;
        op.len = year_len(yr);
      end
      S_MACC: begin
        op.sub = 1'b0;
        op.len = month_len(mo, tgt_y);
      end
      S_YDEC: begin
        op.sub = 1'b1;
        op.len = year_len(yr);
      end
      S_MDEC: begin
        op.sub = 1'b1;
        op.len = month_len(mo, yr);
      end
      default: begin
        op.sub = 1'b0;
        op.len = year_len(yr);
      end
    endcase
  end

  dad_accum u_accum (
    .op     (op),
    .acc    (serial),
    .result (alu_result),
    .ge     (alu_ge)
  );

  // Sequencer: count the start up to a day number, then peel it back down.
  always_comb begin
    state_next  = state;
    serial_next = serial;
    yr_next     = yr;
    mo_next     = mo;
    tgt_y_next  = tgt_y;
    tgt_m_next  = tgt_m;
    res_d_next  = res_d;
    res_m_next  = res_m;
    res_y_next  = res_y;
    unique case (state)
      S_IDLE: begin
        if (in_beat) begin
          yr_next    = YEAR_FIRST;
          mo_next    = 4'd1;
          state_next = S_YACC;
          if (in_ok) begin
            tgt_y_next  = start_year;
            tgt_m_next  = start_month;
            serial_next = SERIAL_W'(start_day - 5'd1) + SERIAL_W'(days_to_add);
          end else begin
            tgt_y_next  = YEAR_FIRST;
            tgt_m_next  = 4'd1;
            serial_next = SERIAL_W'(days_to_add);
          end
        end
      end
      S_YACC: begin
        if (yr == tgt_y) begin
          state_next = S_MACC;
        end else begin
          serial_next = alu_result;
          yr_next     = yr + 12'd1;
        end
      end
      S_MACC: begin
        if (mo == tgt_m) begin
          yr_next    = YEAR_FIRST;
          state_next = S_YDEC;
        end else begin
          serial_next = alu_result;
          mo_next     = mo + 4'd1;
        end
      end
      S_YDEC: begin
        if (alu_ge) begin
          serial_next = alu_result;
          yr_next     = yr + 12'd1;
          if (yr == YEAR_LAST) begin
            // Result runs past the last year: report the epoch date.
            res_d_next = 5'd1;
            res_m_next = 4'd1;
            res_y_next = YEAR_FIRST;
            state_next = S_HOLD;
          end
        end else begin
          mo_next    = 4'd1;
          state_next = S_MDEC;
        end
      end
      S_MDEC: begin
        if ((mo < MONTH_LAST) && alu_ge) begin
          serial_next = alu_result;
          mo_next     = mo + 4'd1;
        end else begin
          res_d_next = serial[4:0] + 5'd1;
          res_m_next = mo;
          res_y_next = yr;
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers and the output register.
  always_ff @(posedge clk) begin
    serial <= serial_next;
    yr     <= yr_next;
    mo     <= mo_next;
    tgt_y  <= tgt_y_next;
    tgt_m  <= tgt_m_next;
    res_d  <= res_d_next;
    res_m  <= res_m_next;
    res_y  <= res_y_next;
    if (out_load) begin
      end_day   <= res_d;
      end_month <= res_m;
      end_year  <= res_y;
    end
  end

  // An accepted beat always starts the year count.
  a_start: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> (state == S_YACC))
    else $error("accepted beat did not start the sequencer");

  // The decode never walks past the last supported year.
  a_year_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_YDEC) |-> (yr >= YEAR_FIRST && yr <= YEAR_LAST))
    else $error("year cursor out of range during decode");

  // Once the years are peeled off, less than one year of days remains.
  a_month_rest: assert property (@(posedge clk) disable iff (rst)
    (state == S_MDEC) |-> (serial < SERIAL_W'(366)))
    else $error("remaining day count too large in month decode");

  // A delivered month is always a real month.
  a_month_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (end_month >= 4'd1 && end_month <= MONTH_LAST))
    else $error("result month out of range");

endmodule
